>>> hw/rtl/dtd_pkg.sv
// Shared types and constants for the delimited telemetry deframer.
// Depends on nothing; every other file of the block imports it.
package dtd_pkg;

   localparam int SLOT_W     = 3;
   localparam int SLOT_IDX_W = 4;
   localparam int LABEL_W    = 8;
   localparam int VALUE_W    = 32;
   localparam int BYTE_W     = 8;
   localparam int LIMIT_W    = 14;
   localparam int OFF_W      = 3;

   localparam logic [OFF_W-1:0] OFF_OPEN  = 3'd0;
   localparam logic [OFF_W-1:0] OFF_LABEL = 3'd1;
   localparam logic [OFF_W-1:0] OFF_VAL0  = 3'd2;
   localparam logic [OFF_W-1:0] OFF_VAL1  = 3'd3;
   localparam logic [OFF_W-1:0] OFF_VAL2  = 3'd4;
   localparam logic [OFF_W-1:0] OFF_VAL3  = 3'd5;
   localparam logic [OFF_W-1:0] OFF_NL    = 3'd6;

   localparam logic [BYTE_W-1:0]  CH_START = 8'h52;
   localparam logic [BYTE_W-1:0]  CH_END   = 8'h58;
   localparam logic [BYTE_W-1:0]  CH_OPEN  = 8'h3C;
   localparam logic [BYTE_W-1:0]  CH_NL    = 8'h0A;
   localparam logic [LABEL_W-1:0] CH_ERR   = 8'h65;

   localparam logic [LIMIT_W-1:0] IDLE_LIMIT_RESET = 14'd10000;

   localparam logic CMD_BYTE = 1'b0;
   localparam logic CMD_TICK = 1'b1;

   typedef struct packed {
      logic                  take;
      logic                  load_lost;
      logic                  load_slot;
      logic [SLOT_IDX_W-1:0] slot_idx;
   } dp_cmd_type;

   typedef struct packed {
      logic is_end;
      logic is_lost;
      logic out_free;
   } dp_sts_type;

endpackage

>>> hw/rtl/dtd_if.sv
// Handshake channel interfaces of the deframer: request, response and register write.
// Depends on dtd_pkg for the field widths.
interface dtd_req_if;
   import dtd_pkg::*;
   logic              valid;
   logic              ready;
   logic              cmd;
   logic [BYTE_W-1:0] rx_byte;
   modport source (output valid, output cmd, output rx_byte, input ready);
   modport sink (input valid, input cmd, input rx_byte, output ready);
endinterface

interface dtd_rsp_if;
   import dtd_pkg::*;
   logic               valid;
   logic               ready;
   logic [SLOT_W-1:0]  slot;
   logic [LABEL_W-1:0] label;
   logic [VALUE_W-1:0] value_bits;
   logic               lost_link;
   logic               last;
   modport source (output valid, output slot, output label, output value_bits,
                   output lost_link, output last, input ready);
   modport sink (input valid, input slot, input label, input value_bits,
                 input lost_link, input last, output ready);
endinterface

interface dtd_csr_if;
   import dtd_pkg::*;
   logic               valid;
   logic               ready;
   logic [LIMIT_W-1:0] data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

>>> hw/rtl/delimited_telemetry_deframer_core.sv
// Delimited telemetry deframer, top level.
// The req channel carries one transaction per received byte (cmd 0) or empty poll
// tick (cmd 1). The rsp channel carries slot results and lost-link results.
// The csr channel writes the 14-bit idle limit; it is always ready and must only
// be written while the block is idle. Reset value of the limit is 10000.
// A lost-link result appears on rsp in the cycle after the tick that causes it.
// A frame end byte sends the controller to its emit state, which loads the first slot result.
// Throughput: one req transaction per cycle while rsp is ready. A frame end byte
// starts a burst of NUM_SLOTS results, one per cycle while rsp is ready, from the
// result register; req stays not ready until the last of them is loaded.
// When the receiver stalls, the single result register holds its transaction and
// req is not ready while a full register could not be drained.
// Synchronous reset returns to hunting for a frame start with the idle count
// cleared, all slots invalid and no result pending.
// Depends on dtd_pkg, dtd_if.sv, dtd_ctrl and dtd_datapath.
module delimited_telemetry_deframer_core #(
   parameter int NUM_SLOTS = 5
) (
   input  logic      clock,
   input  logic      reset,
   dtd_req_if.sink   req_if,
   dtd_rsp_if.source rsp_if,
   dtd_csr_if.sink   csr_if
);
   import dtd_pkg::*;

   dp_cmd_type cmd;
   dp_sts_type sts;
   logic       req_ready;

   assign req_if.ready = req_ready;

   dtd_ctrl #(
      .NUM_SLOTS (NUM_SLOTS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   dtd_datapath #(
      .NUM_SLOTS (NUM_SLOTS)
   ) u_datapath (
      .clock    (clock),
      .reset    (reset),
      .req_cmd  (req_if.cmd),
      .req_byte (req_if.rx_byte),
      .cmd      (cmd),
      .sts      (sts),
      .rsp_if   (rsp_if),
      .csr_if   (csr_if)
   );

endmodule

>>> hw/rtl/dtd_ctrl.sv
// Controller of the deframer: input acceptance and sequencing of frame results.
// Depends on dtd_pkg for the command and status structs.
module dtd_ctrl #(
   parameter int NUM_SLOTS = 5
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  dtd_pkg::dp_sts_type sts,
   output dtd_pkg::dp_cmd_type cmd
);
   import dtd_pkg::*;

   localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_SLOTS - 1);

   typedef enum logic {
      ST_RUN,
      ST_EMIT
   } state_type;

   state_type        state_ff;
   state_type        state_in;
   logic [IDX_W-1:0] emit_idx_ff;
   logic [IDX_W-1:0] emit_idx_in;
   logic             take;

   assign req_ready = (state_ff == ST_RUN) && sts.out_free;
   assign take      = req_valid && req_ready;

   always_comb begin
      state_in    = state_ff;
      emit_idx_in = emit_idx_ff;
      case (state_ff)
         ST_RUN: begin
            if (take && sts.is_end) begin
               state_in    = ST_EMIT;
               emit_idx_in = '0;
            end
         end
         ST_EMIT: begin
            if (sts.out_free) begin
               if (emit_idx_ff == LAST_IDX) begin
                  state_in = ST_RUN;
               end else begin
                  emit_idx_in = emit_idx_ff + 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_RUN;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_RUN;
         emit_idx_ff <= '0;
      end else begin
         state_ff    <= state_in;
         emit_idx_ff <= emit_idx_in;
      end
   end

   always_comb begin
      cmd.take      = take;
      cmd.load_lost = take && sts.is_lost;
      cmd.load_slot = (state_ff == ST_EMIT) && sts.out_free;
      cmd.slot_idx  = SLOT_IDX_W'(emit_idx_ff);
   end

`ifndef SYNTH
   a_no_double_load: assert property (@(posedge clock) disable iff (reset)
      !(cmd.load_lost && cmd.load_slot))
      else $error("lost-link and slot result loaded in the same cycle");

   a_end_starts_emit: assert property (@(posedge clock) disable iff (reset)
      (take && sts.is_end) |=> (state_ff == ST_EMIT && emit_idx_ff == '0))
      else $error("frame end did not start result sequence at slot zero");

   a_emit_returns: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT && sts.out_free && emit_idx_ff == LAST_IDX)
      |=> (state_ff == ST_RUN))
      else $error("result sequence did not end after the final slot");
`endif

endmodule

>>> hw/rtl/dtd_datapath.sv
// Datapath of the deframer: slot storage, idle counter, limit register, result register.
// Depends on dtd_pkg and the channel interfaces in dtd_if.sv.
module dtd_datapath #(
   parameter int NUM_SLOTS = 5
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_cmd,
   input  logic [dtd_pkg::BYTE_W-1:0]  req_byte,
   input  dtd_pkg::dp_cmd_type         cmd,
   output dtd_pkg::dp_sts_type         sts,
   dtd_rsp_if.source                   rsp_if,
   dtd_csr_if.sink                     csr_if
);
   import dtd_pkg::*;

   localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
   localparam int CNT_W = $clog2(NUM_SLOTS + 1);
   localparam logic [CNT_W-1:0]      SLOT_COUNT = CNT_W'(NUM_SLOTS);
   localparam logic [SLOT_IDX_W-1:0] LAST_IDX   = SLOT_IDX_W'(NUM_SLOTS - 1);

   logic [LIMIT_W-1:0] limit_ff, limit_in;
   logic [LIMIT_W-1:0] idle_ff, idle_in;
   logic               in_frame_ff, in_frame_in;
   logic [CNT_W-1:0]   wr_slot_ff, wr_slot_in;
   logic [OFF_W-1:0]   wr_off_ff, wr_off_in;

   logic [LABEL_W-1:0] labels_ff [NUM_SLOTS];
   logic [LABEL_W-1:0] labels_in [NUM_SLOTS];
   logic [VALUE_W-1:0] values_ff [NUM_SLOTS];
   logic [VALUE_W-1:0] values_in [NUM_SLOTS];
   logic               ok_ff     [NUM_SLOTS];
   logic               ok_in     [NUM_SLOTS];

   logic               out_valid_ff, out_valid_in;
   logic [SLOT_W-1:0]  out_slot_ff, out_slot_in;
   logic [LABEL_W-1:0] out_label_ff, out_label_in;
   logic [VALUE_W-1:0] out_value_ff, out_value_in;
   logic               out_lost_ff, out_lost_in;
   logic               out_last_ff, out_last_in;

   logic [IDX_W-1:0]   wr_idx;
   logic [IDX_W-1:0]   rd_idx;
   logic               rd_ok;

   assign csr_if.ready = 1'b1;
   assign wr_idx = wr_slot_ff[IDX_W-1:0];
   assign rd_idx = cmd.slot_idx[IDX_W-1:0];
   assign rd_ok  = ok_ff[rd_idx] && (CNT_W'(rd_idx) < wr_slot_ff);

   always_comb begin
      sts.is_end   = (req_cmd == CMD_BYTE) && in_frame_ff && (req_byte == CH_END);
      sts.is_lost  = (req_cmd == CMD_TICK) && !(idle_ff < limit_ff);
      sts.out_free = !out_valid_ff || rsp_if.ready;
   end

   always_comb begin
      limit_in    = limit_ff;
      idle_in     = idle_ff;
      in_frame_in = in_frame_ff;
      wr_slot_in  = wr_slot_ff;
      wr_off_in   = wr_off_ff;
      labels_in   = labels_ff;
      values_in   = values_ff;
      ok_in       = ok_ff;

      if (csr_if.valid) begin
         limit_in = csr_if.data;
      end

      if (cmd.take) begin
         if (req_cmd == CMD_TICK) begin
            if (sts.is_lost) begin
               idle_in     = '0;
               in_frame_in = 1'b0;
            end else begin
               idle_in = idle_ff + 1'b1;
            end
         end else begin
            idle_in = '0;
            if (!in_frame_ff) begin
               if (req_byte == CH_START) begin
                  in_frame_in = 1'b1;
                  wr_slot_in  = '0;
                  wr_off_in   = OFF_OPEN;
               end
            end else if (req_byte == CH_END) begin
               in_frame_in = 1'b0;
            end else if (wr_slot_ff < SLOT_COUNT) begin
               case (wr_off_ff)
                  OFF_OPEN:  ok_in[wr_idx] = (req_byte == CH_OPEN);
                  OFF_LABEL: labels_in[wr_idx] = req_byte;
                  OFF_VAL0:  values_in[wr_idx][7:0] = req_byte;
                  OFF_VAL1:  values_in[wr_idx][15:8] = req_byte;
                  OFF_VAL2:  values_in[wr_idx][23:16] = req_byte;
                  OFF_VAL3:  values_in[wr_idx][31:24] = req_byte;
                  OFF_NL:    ok_in[wr_idx] = ok_ff[wr_idx] && (req_byte == CH_NL);
                  default:   ok_in[wr_idx] = 1'b0;
               endcase
               if (wr_off_ff == OFF_NL) begin
                  wr_off_in  = OFF_OPEN;
                  wr_slot_in = wr_slot_ff + 1'b1;
               end else begin
                  wr_off_in = wr_off_ff + 1'b1;
               end
            end
         end
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff && !rsp_if.ready;
      out_slot_in  = out_slot_ff;
      out_label_in = out_label_ff;
      out_value_in = out_value_ff;
      out_lost_in  = out_lost_ff;
      out_last_in  = out_last_ff;
      if (cmd.load_lost) begin
         out_valid_in = 1'b1;
         out_slot_in  = '0;
         out_label_in = '0;
         out_value_in = '0;
         out_lost_in  = 1'b1;
         out_last_in  = 1'b1;
      end else if (cmd.load_slot) begin
         out_valid_in = 1'b1;
         out_slot_in  = cmd.slot_idx[SLOT_W-1:0];
         out_label_in = rd_ok ? labels_ff[rd_idx] : CH_ERR;
         out_value_in = rd_ok ? values_ff[rd_idx] : '0;
         out_lost_in  = 1'b0;
         out_last_in  = (cmd.slot_idx == LAST_IDX);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff     <= IDLE_LIMIT_RESET;
         idle_ff      <= '0;
         in_frame_ff  <= 1'b0;
         wr_slot_ff   <= '0;
         wr_off_ff    <= OFF_OPEN;
         out_valid_ff <= 1'b0;
         for (int i = 0; i < NUM_SLOTS; i++) begin
            ok_ff[i] <= 1'b0;
         end
      end else begin
         limit_ff     <= limit_in;
         idle_ff      <= idle_in;
         in_frame_ff  <= in_frame_in;
         wr_slot_ff   <= wr_slot_in;
         wr_off_ff    <= wr_off_in;
         out_valid_ff <= out_valid_in;
         ok_ff        <= ok_in;
      end
   end

   always_ff @(posedge clock) begin
      labels_ff    <= labels_in;
      values_ff    <= values_in;
      out_slot_ff  <= out_slot_in;
      out_label_ff <= out_label_in;
      out_value_ff <= out_value_in;
      out_lost_ff  <= out_lost_in;
      out_last_ff  <= out_last_in;
   end

   assign rsp_if.valid      = out_valid_ff;
   assign rsp_if.slot       = out_slot_ff;
   assign rsp_if.label      = out_label_ff;
   assign rsp_if.value_bits = out_value_ff;
   assign rsp_if.lost_link  = out_lost_ff;
   assign rsp_if.last       = out_last_ff;

`ifndef SYNTH
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (cmd.load_lost || cmd.load_slot) |-> (!out_valid_ff || rsp_if.ready))
      else $error("result register loaded while holding an untaken transaction");

   a_lost_result: assert property (@(posedge clock) disable iff (reset)
      cmd.load_lost |=> (out_valid_ff && out_lost_ff && out_last_ff && !in_frame_ff))
      else $error("lost-link transaction not formed or frame left open");

   a_end_closes: assert property (@(posedge clock) disable iff (reset)
      (cmd.take && sts.is_end) |=> !in_frame_ff)
      else $error("frame still open after its end byte");
`endif

endmodule
